FILE: sv/mlfs_pkg.sv
// Shared types, constants and a helper function for the memory LCD framebuffer streamer.
// Used by the controller, the datapath and the top level; depends on nothing else.
package mlfs_pkg;

    // Item kinds carried on the input channel's tuser.
    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_REFRESH = 2'd2,
        KIND_TICK    = 2'd3
    } kind_t;

    // Quarter-turn codes of the rotation register.
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // Source of the next byte on the link.
    typedef enum logic [2:0] {
        SEL_CMD_WRITE,
        SEL_CMD_CLEAR,
        SEL_LINE_NO,
        SEL_DUMMY,
        SEL_DATA
    } out_sel_t;

    localparam logic [7:0] CMD_WRITE   = 8'h80;
    localparam logic [7:0] CMD_CLEAR   = 8'h20;
    localparam logic [7:0] DUMMY_BYTE  = 8'h00;
    localparam logic [2:0] BIT_IN_BYTE = 3'b111;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     pix_load;       // capture rotated pixel coordinates
        logic     pix_addr_load;  // form the byte address of the pixel
        logic     rd_pix;         // read the byte that holds the pixel
        logic     wr_pix;         // write back the modified byte
        logic     rd_ptr;         // read the frame byte at the store pointer
        logic     sweep_en;       // write zero at the sweep address
        logic     refresh_start;  // restart the line, byte and store counters
        logic     line_init;      // line counter to one
        logic     line_inc;
        logic     byte_clr;
        logic     byte_inc;       // also advances the store pointer
        logic     out_load;       // load the output register
        out_sel_t out_sel;
        logic     out_last;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pix_in_range;
        logic sweep_last;
        logic line_last;
        logic byte_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

endpackage

FILE: sv/mlfs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; no package dependency.
module mlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1152
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/mlfs_ctrl.sv
// Controller for the framebuffer streamer: input handshake, store sweeps, pixel
// read-modify-write sequencing and the transfer byte sequence. Depends on mlfs_pkg.
module mlfs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mlfs_pkg::kind_t      kind,
    input  mlfs_pkg::dp_status_t status,
    output mlfs_pkg::ctrl_cmd_t  cmd
);
    import mlfs_pkg::*;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_FETCH,
        ST_PIX_ADDR,
        ST_PIX_RD,
        ST_PIX_WR
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_LINE_NO,
        PH_DATA,
        PH_LINE_DUMMY,
        PH_FINAL
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   is_clear_reg, is_clear_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        is_clear_next = is_clear_reg;
        cmd           = '0;
        cmd.out_sel   = SEL_DUMMY;

        case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_en = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (kind)
                        KIND_TICK: begin
                            case (phase_reg)
                                PH_CMD: begin
                                    cmd.out_load = 1'b1;
                                    if (is_clear_reg) begin
                                        cmd.out_sel = SEL_CMD_CLEAR;
                                        phase_next  = PH_FINAL;
                                    end else begin
                                        cmd.out_sel   = SEL_CMD_WRITE;
                                        cmd.line_init = 1'b1;
                                        phase_next    = PH_LINE_NO;
                                    end
                                end
                                PH_LINE_NO: begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_sel  = SEL_LINE_NO;
                                    cmd.byte_clr = 1'b1;
                                    phase_next   = PH_DATA;
                                end
                                PH_DATA: begin
                                    // The byte comes from the store; ST_FETCH then loads it into the output register.
                                    cmd.rd_ptr   = 1'b1;
                                    cmd.byte_inc = 1'b1;
                                    state_next   = ST_FETCH;
                                    if (status.byte_last) begin
                                        phase_next = PH_LINE_DUMMY;
                                    end
                                end
                                PH_LINE_DUMMY: begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_sel  = SEL_DUMMY;
                                    cmd.line_inc = 1'b1;
                                    phase_next   = status.line_last ? PH_FINAL : PH_LINE_NO;
                                end
                                PH_FINAL: begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_sel  = SEL_DUMMY;
                                    cmd.out_last = 1'b1;
                                    phase_next   = PH_IDLE;
                                end
                                default: begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                        KIND_PIXEL: begin
                            if (phase_reg == PH_IDLE && status.pix_in_range) begin
                                cmd.pix_load = 1'b1;
                                state_next   = ST_PIX_ADDR;
                            end
                        end
                        KIND_CLEAR: begin
                            if (phase_reg == PH_IDLE) begin
                                is_clear_next = 1'b1;
                                phase_next    = PH_CMD;
                                state_next    = ST_SWEEP;
                            end
                        end
                        KIND_REFRESH: begin
                            if (phase_reg == PH_IDLE) begin
                                is_clear_next     = 1'b0;
                                cmd.refresh_start = 1'b1;
                                phase_next        = PH_CMD;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_DATA;
                state_next   = ST_IDLE;
            end
            ST_PIX_ADDR: begin
                cmd.pix_addr_load = 1'b1;
                state_next        = ST_PIX_RD;
            end
            ST_PIX_RD: begin
                cmd.rd_pix = 1'b1;
                state_next = ST_PIX_WR;
            end
            ST_PIX_WR: begin
                cmd.wr_pix = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            phase_reg    <= PH_IDLE;
            is_clear_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            is_clear_reg <= is_clear_next;
        end
    end

endmodule

FILE: sv/mlfs_dpath.sv
// Datapath for the framebuffer streamer: rotation register, pixel coordinate
// transform, frame store RAM, transfer counters and output register.
// Depends on mlfs_pkg and mlfs_ram.
module mlfs_dpath #(
    parameter int PANEL_WIDTH  = 96,
    parameter int PANEL_HEIGHT = 96
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic signed [15:0]   pixel_x,
    input  logic signed [15:0]   pixel_y,
    input  logic                 pixel_on,
    input  mlfs_pkg::ctrl_cmd_t  cmd,
    output mlfs_pkg::dp_status_t status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tlast
);
    import mlfs_pkg::*;

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int LINE_BYTES  = PANEL_WIDTH / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PTR_W       = $clog2(STORE_BYTES + 1);
    localparam int BYTE_W      = $clog2(LINE_BYTES + 1);
    localparam int XW          = $clog2(PANEL_WIDTH);
    localparam int YW          = $clog2(PANEL_HEIGHT + 1);
    localparam int LIN_W       = $clog2(PANEL_WIDTH * PANEL_HEIGHT);

    localparam logic [15:0] W16 = 16'(PANEL_WIDTH);
    localparam logic [15:0] H16 = 16'(PANEL_HEIGHT);

    logic [1:0]        rotation_reg;
    logic [XW-1:0]     xf_reg;
    logic [YW-1:0]     yf_reg;
    logic              on_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [2:0]        bit_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic [7:0]        line_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_last_reg;

    logic [15:0]       xu, yu, rw16, rh16, xf16, yf16;
    logic [LIN_W-1:0]  lin;
    logic [7:0]        mask;
    logic [7:0]        ram_rd_data;
    logic [7:0]        ram_wr_data;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [7:0]        out_byte;

    // Bounds check against the rotated panel, then rotation and x mirror in one step.
    assign xu   = pixel_x;
    assign yu   = pixel_y;
    assign rw16 = rotation_reg[0] ? H16 : W16;
    assign rh16 = rotation_reg[0] ? W16 : H16;

    always_comb begin
        case (rot_t'(rotation_reg))
            ROT_0: begin
                xf16 = W16 - 16'd1 - xu;
                yf16 = yu;
            end
            ROT_90: begin
                xf16 = yu;
                yf16 = xu;
            end
            ROT_180: begin
                xf16 = xu;
                yf16 = H16 - 16'd1 - yu;
            end
            ROT_270: begin
                xf16 = W16 - 16'd1 - yu;
                yf16 = H16 - 16'd1 - xu;
            end
            default: begin
                xf16 = xu;
                yf16 = yu;
            end
        endcase
    end

    assign status.pix_in_range = !pixel_x[15] && !pixel_y[15] && (xu < rw16) && (yu < rh16);
    assign status.sweep_last   = (sweep_reg == ADDR_W'(STORE_BYTES - 1));
    assign status.line_last    = (line_reg == 8'(PANEL_HEIGHT));
    assign status.byte_last    = (byte_reg == BYTE_W'(LINE_BYTES - 1));
    assign status.out_free     = !out_valid_reg || m_tready;

    assign lin  = LIN_W'(LIN_W'(yf_reg) * LIN_W'(PANEL_WIDTH)) + LIN_W'(xf_reg);
    assign mask = 8'd1 << bit_reg;

    // Frame store: sweeps and pixel write-backs share the write port.
    assign ram_wr_en   = cmd.sweep_en || cmd.wr_pix;
    assign ram_wr_addr = cmd.sweep_en ? sweep_reg : addr_reg;
    assign ram_wr_data = cmd.sweep_en ? DUMMY_BYTE
                       : (on_reg ? (ram_rd_data | mask) : (ram_rd_data & ~mask));
    assign ram_rd_en   = cmd.rd_pix || cmd.rd_ptr;
    assign ram_rd_addr = cmd.rd_pix ? addr_reg : ptr_reg[ADDR_W-1:0];

    mlfs_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        case (cmd.out_sel)
            SEL_CMD_WRITE: out_byte = CMD_WRITE;
            SEL_CMD_CLEAR: out_byte = CMD_CLEAR;
            SEL_LINE_NO:   out_byte = reverse8(line_reg);
            SEL_DATA:      out_byte = reverse8(ram_rd_data);
            default:       out_byte = DUMMY_BYTE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg  <= ROT_0;
            sweep_reg     <= '0;
            line_reg      <= '0;
            byte_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                rotation_reg <= cfg_wr_data;
            end
            if (cmd.sweep_en) begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + ADDR_W'(1);
            end
            if (cmd.refresh_start) begin
                line_reg <= '0;
                byte_reg <= '0;
                ptr_reg  <= '0;
            end
            if (cmd.line_init) begin
                line_reg <= 8'd1;
            end
            if (cmd.line_inc) begin
                line_reg <= line_reg + 8'd1;
            end
            if (cmd.byte_clr) begin
                byte_reg <= '0;
            end
            if (cmd.byte_inc) begin
                byte_reg <= byte_reg + BYTE_W'(1);
                ptr_reg  <= ptr_reg + PTR_W'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.pix_load) begin
            xf_reg <= XW'(xf16);
            yf_reg <= YW'(yf16);
            on_reg <= pixel_on;
        end
        if (cmd.pix_addr_load) begin
            addr_reg <= ADDR_W'(lin >> 3);
            bit_reg  <= xf_reg[2:0] & BIT_IN_BYTE;
        end
        if (cmd.out_load) begin
            out_data_reg <= out_byte;
            out_last_reg <= cmd.out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/memory_lcd_framebuffer_streamer_core.sv
// Memory LCD framebuffer streamer, top level.
// Throughput: one item per cycle while the output is free, for ticks outside the frame data,
// refreshes and dropped items; a data tick, pixel or clear keeps s_tready low in ST_FETCH, the
// read-modify-write or the sweep. A tick's byte is on m_tdata the cycle after acceptance,
// data bytes after the RAM read. Reset (aresetn, synchronous, active low) clears control state,
// then zeroes all (W*H+7)/8 store bytes (1152 at 96x96), one byte a cycle, with s_tready low.
module memory_lcd_framebuffer_streamer_core #(
    parameter int PANEL_WIDTH  = 96,
    parameter int PANEL_HEIGHT = 96
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Rotation register: quarter turns applied to pixel coordinates.
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pixel_x[15:0], pixel_y[31:16], pixel_on[32], zeros above
    input  logic [1:0]  s_tuser,   // kind[1:0]

    // Serial link bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // wire_byte[7:0]
    output logic        m_tlast    // last_of_transfer
);
    import mlfs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller owns the handshake and sequencing: a clear item starts the
    // same zeroing sweep that follows reset, a refresh item arms the byte
    // sequence, and each tick steps through command, line numbers, frame data
    // and dummy bytes. Non-tick items that arrive during a transfer are dropped.
    mlfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (kind_t'(s_tuser)),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the frame store and rotates, mirrors and bounds-checks
    // pixel coordinates. Frame bytes and line numbers leave bit-reversed since
    // the panel takes them least significant bit first.
    mlfs_dpath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pixel_x     (s_tdata[15:0]),
        .pixel_y     (s_tdata[31:16]),
        .pixel_on    (s_tdata[32]),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for memory_lcd_framebuffer_streamer_core: pixel, clear, refresh and tick
// items go in, link bytes are predicted by a bit-accurate framebuffer model and compared.
// Depends on mlfs_pkg (item kinds, rotation codes, command bytes) and the core itself.
module tb;
    import mlfs_pkg::*;

    localparam int PANEL_W     = 96;
    localparam int PANEL_H     = 96;
    localparam int STORE_BYTES = (PANEL_W * PANEL_H + 7) / 8;
    localparam int LINE_BYTES  = PANEL_W / 8;

    // One byte on the serial link together with its end-of-transfer flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } link_byte_t;

    // Framebuffer predictor and the queue of link bytes it still expects to see.
    class frame_scoreboard;
        typedef enum int {
            XF_IDLE,
            XF_CMD,
            XF_LINE_NO,
            XF_DATA,
            XF_LINE_DUMMY,
            XF_FINAL
        } xfer_e;

        logic [7:0]  frame [STORE_BYTES];
        rot_t        rot;
        xfer_e       phase;
        bit          is_clear;
        int          line_no;
        int          byte_no;
        int          ptr;
        link_byte_t  link_q[$];
        int          errors;

        function new();
            foreach (frame[i]) frame[i] = 8'h00;
            rot      = ROT_0;
            phase    = XF_IDLE;
            is_clear = 1'b0;
            line_no  = 0;
            byte_no  = 0;
            ptr      = 0;
            errors   = 0;
        endfunction

        function void set_rotation(rot_t r);
            rot = r;
        endfunction

        function bit busy();
            return phase != XF_IDLE;
        endfunction

        function int pending();
            return link_q.size();
        endfunction

        // The panel takes line numbers and frame bytes LSB first.
        function logic [7:0] flip(logic [7:0] v);
            return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
        endfunction

        function void draw(int x, int y, logic on);
            int rw;
            int rh;
            int t;
            int idx;
            rw = rot[0] ? PANEL_H : PANEL_W;
            rh = rot[0] ? PANEL_W : PANEL_H;
            if (x < 0 || x >= rw || y < 0 || y >= rh) return;
            case (rot)
                ROT_90: begin
                    t = x;
                    x = PANEL_W - 1 - y;
                    y = t;
                end
                ROT_180: begin
                    x = PANEL_W - 1 - x;
                    y = PANEL_H - 1 - y;
                end
                ROT_270: begin
                    t = x;
                    x = y;
                    y = PANEL_H - 1 - t;
                end
                default: ;
            endcase
            x   = PANEL_W - 1 - x;
            idx = (y * PANEL_W + x) / 8;
            if (idx >= STORE_BYTES) return;
            frame[idx][x % 8] = on;
        endfunction

        function link_byte_t next_byte();
            link_byte_t b;
            b.data = DUMMY_BYTE;
            b.last = 1'b0;
            case (phase)
                XF_CMD: begin
                    if (is_clear) begin
                        b.data = CMD_CLEAR;
                        phase  = XF_FINAL;
                    end else begin
                        b.data  = CMD_WRITE;
                        line_no = 1;
                        phase   = XF_LINE_NO;
                    end
                end
                XF_LINE_NO: begin
                    b.data  = flip(8'(line_no));
                    byte_no = 0;
                    if (LINE_BYTES > 0) phase = XF_DATA;
                    else phase = XF_LINE_DUMMY;
                end
                XF_DATA: begin
                    b.data = (ptr < STORE_BYTES) ? flip(frame[ptr]) : 8'h00;
                    ptr++;
                    byte_no++;
                    if (byte_no >= LINE_BYTES) phase = XF_LINE_DUMMY;
                end
                XF_LINE_DUMMY: begin
                    line_no++;
                    if (line_no <= PANEL_H) phase = XF_LINE_NO;
                    else phase = XF_FINAL;
                end
                XF_FINAL: begin
                    b.last = 1'b1;
                    phase  = XF_IDLE;
                end
                default: phase = XF_IDLE;
            endcase
            return b;
        endfunction

        function void note_input(kind_t k, logic [15:0] px, logic [15:0] py, logic on);
            int sx;
            int sy;
            sx = $signed(px);
            sy = $signed(py);
            if (k == KIND_TICK) begin
                if (phase != XF_IDLE) link_q.push_back(next_byte());
                return;
            end
            if (phase != XF_IDLE) return;
            case (k)
                KIND_PIXEL: draw(sx, sy, on);
                KIND_CLEAR: begin
                    foreach (frame[i]) frame[i] = 8'h00;
                    is_clear = 1'b1;
                    phase    = XF_CMD;
                end
                default: begin
                    is_clear = 1'b0;
                    line_no  = 0;
                    byte_no  = 0;
                    ptr      = 0;
                    phase    = XF_CMD;
                end
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic [7:0] data, logic last);
            link_byte_t want;
            if (link_q.size() == 0) begin
                report($sformatf("unexpected link byte %02h last=%0b", data, last));
                return;
            end
            want = link_q.pop_front();
            if (data !== want.data)
                report($sformatf("link byte %02h, expected %02h", data, want.data));
            if (last !== want.last)
                report($sformatf("tlast %0b, expected %0b (byte %02h)", last, want.last, data));
        endtask
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    frame_scoreboard sb;
    bit              no_idle = 1'b0;  // both sides run without gaps while this is set
    int              rx_stall = 0;
    int              pixel_items = 0;

    memory_lcd_framebuffer_streamer_core #(
        .PANEL_WIDTH (PANEL_W),
        .PANEL_HEIGHT(PANEL_H)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Link side: every accepted byte is checked against the oldest prediction, and tready
    // is dropped for random stretches. Signals are sampled at the edge before the core's
    // registers update, so the checker sees exactly what the core saw.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (no_idle) begin
            m_tready <= 1'b1;
        end else begin
            rx_stall = idle_len();
            m_tready <= (rx_stall == 0);
        end
    end

    // Present one item, hold it until the handshake completes, then tell the predictor.
    // The caller is always at a rising edge, so valid gets a single update per step: either
    // lowered for a gap or kept high with new data for a back-to-back item.
    task automatic send_item(kind_t k, logic [15:0] px, logic [15:0] py, logic on);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {7'd0, on, py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(k, px, py, on);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // Any kind but a tick, with random fields in every bit.
    task automatic send_noise();
        send_item(kind_t'($urandom_range(0, 2)), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    // A pixel write, mostly on the rotated panel, some just off an edge, some anywhere.
    task automatic send_pixel();
        int r;
        int rw;
        int rh;
        int x;
        int y;
        rw = sb.rot[0] ? PANEL_H : PANEL_W;
        rh = sb.rot[0] ? PANEL_W : PANEL_H;
        x  = $urandom_range(0, rw - 1);
        y  = $urandom_range(0, rh - 1);
        r  = $urandom_range(0, 99);
        if (r >= 95) begin
            x = $signed(16'($urandom));
            y = $signed(16'($urandom));
        end else if (r >= 85) begin
            case ($urandom_range(0, 3))
                0: x = -1;
                1: x = rw;
                2: y = -1;
                default: y = rh;
            endcase
        end
        send_item(KIND_PIXEL, 16'(x), 16'(y), 1'($urandom_range(0, 9) < 6));
        pixel_items++;
    endtask

    // Tick the running transfer to its end. Now and then another item is slipped in while
    // the transfer is busy; the core must drop it.
    task automatic finish_transfer();
        while (sb.busy()) begin
            if ($urandom_range(0, 99) < 4) send_noise();
            else send_tick();
        end
    endtask

    // Stop sending and wait until every predicted byte has arrived, then give a pending
    // read-modify-write time to land before anything touches the configuration.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // Only called with s_tvalid low and no item in flight.
    task automatic write_rotation(rot_t r);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= r;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_rotation(r);
    endtask

    // One rotation setting: random bursts of pixels, clears and stray ticks, closed by a
    // full refresh that reads back the whole frame.
    task automatic run_phase(rot_t r);
        int target;
        int n;
        int sel;
        write_rotation(r);
        target = pixel_items + 200;
        while (pixel_items < target) begin
            no_idle = ($urandom_range(0, 99) < 15);
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                n = $urandom_range(5, 30);
                repeat (n) begin
                    if ($urandom_range(0, 99) < 5) send_tick();
                    else send_pixel();
                end
            end else if (sel < 83) begin
                send_item(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
                finish_transfer();
            end else if (sel < 93) begin
                n = $urandom_range(1, 5);
                repeat (n) send_tick();
            end else begin
                wait_drained();
            end
        end
        no_idle = ($urandom_range(0, 99) < 20);
        send_item(KIND_REFRESH, 16'($urandom), 16'($urandom), 1'($urandom));
        finish_transfer();
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at rotation zero: corners, neighboring bytes, a cleared bit, every
        // kind of off-panel pixel and the extremes of the coordinate fields.
        write_rotation(ROT_0);
        send_item(KIND_PIXEL, 16'd0, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd95, 16'd95, 1'b1);
        send_item(KIND_PIXEL, 16'd95, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd0, 16'd95, 1'b1);
        send_item(KIND_PIXEL, 16'd7, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd8, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd95, 16'd95, 1'b0);
        send_item(KIND_PIXEL, 16'hFFFF, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd0, 16'hFFFF, 1'b1);
        send_item(KIND_PIXEL, 16'd96, 16'd0, 1'b1);
        send_item(KIND_PIXEL, 16'd0, 16'd96, 1'b1);
        send_item(KIND_PIXEL, 16'h8000, 16'h7FFF, 1'b1);
        send_item(KIND_PIXEL, 16'h7FFF, 16'h8000, 1'b1);
        // A tick with nothing running gives no byte, whatever its unused fields hold.
        send_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 1'b1);
        // Refresh, then pixel, clear and refresh items that arrive while it is busy.
        send_item(KIND_REFRESH, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(KIND_PIXEL, 16'd10, 16'd10, 1'b1);
        send_item(KIND_CLEAR, 16'd0, 16'd0, 1'b0);
        send_item(KIND_REFRESH, 16'd0, 16'd0, 1'b0);
        finish_transfer();
        // Clear with a pixel that has to be dropped while the clear command is queued.
        send_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1);
        send_item(KIND_PIXEL, 16'd1, 16'd1, 1'b1);
        finish_transfer();
        send_tick();
        // The sender holds back here until every predicted byte is out.
        wait_drained();

        // Random part: both quarter turns that swap the axes first, then a half turn and a random one.
        run_phase(ROT_270);
        run_phase(ROT_90);
        run_phase(ROT_180);
        run_phase(rot_t'($urandom_range(0, 3)));

        // Give the core time to emit anything it should not, then decide.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (32) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog against a hung handshake; far beyond any correct run.
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
